[hdl/stwa_pkg.sv]
`default_nettype none
package stwa_pkg;
   localparam int SLOTS = 64;
   localparam int IDX_BITS = 6;
   localparam int ID_BITS = 50;
   localparam logic [ID_BITS-1:0] ID_MAX = 50'd999999999999999;

   localparam logic [2:0] MODE_CREATE = 3'd0;
   localparam logic [2:0] MODE_TERM   = 3'd1;
   localparam logic [2:0] MODE_DENY   = 3'd2;
   localparam logic [2:0] MODE_SWEEP  = 3'd3;
   localparam logic [2:0] MODE_DRAIN  = 3'd4;
   localparam logic [2:0] MODE_TICK   = 3'd5;
   localparam logic [2:0] MODE_STATS  = 3'd6;
   localparam logic [2:0] MODE_NONE   = 3'd7;

   localparam logic [3:0] EV_CREATED     = 4'd0;
   localparam logic [3:0] EV_BLACKLISTED = 4'd1;
   localparam logic [3:0] EV_EXISTS      = 4'd2;
   localparam logic [3:0] EV_UNAVAILABLE = 4'd3;
   localparam logic [3:0] EV_FULL        = 4'd4;
   localparam logic [3:0] EV_DELETED     = 4'd5;
   localparam logic [3:0] EV_NOTFOUND    = 4'd6;
   localparam logic [3:0] EV_BL_ADDED    = 4'd7;
   localparam logic [3:0] EV_BL_REFUSED  = 4'd8;
   localparam logic [3:0] EV_DONE        = 4'd9;
   localparam logic [3:0] EV_STATS       = 4'd10;
   localparam logic [3:0] EV_TICK        = 4'd11;

   localparam logic CSR_TIMEOUT  = 1'b0;
   localparam logic CSR_INTERVAL = 1'b1;

   typedef struct packed {
      logic [2:0]         mode;
      logic [ID_BITS-1:0] subscriber_id;
   } req_type;

   typedef struct packed {
      logic [3:0]         event_res;
      logic [ID_BITS-1:0] event_id;
      logic [6:0]         active_count;
      logic [31:0]        created_count;
      logic [31:0]        rejected_count;
      logic [31:0]        attempt_count;
      logic [31:0]        terminated_count;
      logic [31:0]        expired_count;
      logic [31:0]        uptime_ticks;
      logic               last;
   } rsp_type;
endpackage
`default_nettype wire

[hdl/stwa_ram.sv]
`default_nettype none
module stwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hdl/session_table_with_aging.sv]
`default_nettype none
// Session table with aging and a blacklist.
// req_: one command (mode, subscriber_id) per transfer while req_valid and
//   !req_stall. req_stall is high while a command is in progress and while
//   a result sits stalled in the output register.
// rsp_: one or more results per command (none for MODE_NONE); the final one has last set.
//   A sweep scan step waits while the result register is held.
// csr_: write-only; index 0 session timeout, index 1 drain interval.
// Create walks all 64 deny store entries, then, unless the subscriber is
//   blacklisted, all 64 session store entries. Terminate, blacklist add,
//   sweep and drain ticks walk one store; a sweep also waits on output stalls.
//   Start drain, plain ticks, stats, out-of-range blacklist adds and creates
//   while draining answer without a walk. Each memory has a single read port,
//   so a walk examines one entry per cycle, a sweep only while the result register is not held.
// Throughput: one command at a time; the next is taken at the edge where
//   the final result of the previous one transfers.
// Reset clears valid bits, counters, time and drain state;
//   memory contents are only read under a valid bit.
// A stalled rsp_ holds a sweep scan until the result is taken.
module session_table_with_aging (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire stwa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output stwa_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [31:0]       csr_data
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DENY = 3'd1;
   localparam logic [2:0] S_SLOT = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;

   logic [2:0] state_ff, state_in;
   stwa_pkg::req_type cmd_ff, cmd_in;
   logic [6:0] ptr_ff, ptr_in;            // read address issued, one ahead
   logic [5:0] chk_ff, chk_in;            // entry whose data is on rd_data
   logic       chk_vld_ff, chk_vld_in;
   logic       hit_ff, hit_in;
   logic       free_ok_ff, free_ok_in;
   logic [5:0] free_ff, free_in;
   logic       any_ff, any_in;
   logic [49:0] pkey_ff, pkey_in;         // sweep deletion not yet sent
   logic [63:0] sval_ff, sval_in, dval_ff, dval_in;
   logic [6:0]  act_ff, act_in;
   logic [31:0] timeout_ff, timeout_in;
   logic [9:0]  intv_ff, intv_in;
   logic        drain_ff, drain_in;
   logic [31:0] now_ff, now_in, dwait_ff, dwait_in;
   logic [31:0] c_cr_ff, c_rj_ff, c_at_ff, c_tm_ff, c_ex_ff;
   logic [31:0] c_cr_in, c_rj_in, c_at_in, c_tm_in, c_ex_in;
   logic        ov_ff, ov_in;
   logic [3:0]  oev_ff, oev_in;
   logic [49:0] oid_ff, oid_in;
   logic        olast_ff, olast_in;
   logic        orefresh_ff, orefresh_in;

   logic        s_we, d_we;
   logic [5:0]  s_wa, d_wa, s_ra, d_ra;
   logic [49:0] s_key_rd, d_key_rd;
   logic [31:0] s_birth_rd;
   logic [49:0] s_wkey;

   stwa_ram #(.WIDTH(50), .DEPTH(stwa_pkg::SLOTS)) u_key (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wkey),
      .rd_addr(s_ra), .rd_data(s_key_rd));
   stwa_ram #(.WIDTH(32), .DEPTH(stwa_pkg::SLOTS)) u_birth (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(now_ff),
      .rd_addr(s_ra), .rd_data(s_birth_rd));
   stwa_ram #(.WIDTH(50), .DEPTH(stwa_pkg::SLOTS)) u_deny (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(cmd_ff.subscriber_id),
      .rd_addr(d_ra), .rd_data(d_key_rd));

   logic out_free;
   logic scan_hold;
   logic [31:0] iv;
   logic [31:0] age;
   assign out_free = !ov_ff || !rsp_stall;
   // a held sweep re-reads the entry under check so its data stays on rd_data
   assign scan_hold = (state_ff == S_SLOT) && (cmd_ff.mode == stwa_pkg::MODE_SWEEP)
                      && !out_free;
   assign iv = (intv_ff == 10'd0) ? 32'd1 : {22'd0, intv_ff};
   assign age = now_ff - s_birth_rd;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign s_ra = scan_hold ? chk_ff : ptr_ff[5:0];
   assign d_ra = ptr_ff[5:0];

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; ptr_in = ptr_ff; chk_in = chk_ff;
      chk_vld_in = 1'b0; hit_in = hit_ff; free_ok_in = free_ok_ff;
      free_in = free_ff; any_in = any_ff; pkey_in = pkey_ff;
      sval_in = sval_ff; dval_in = dval_ff;
      act_in = act_ff; timeout_in = timeout_ff; intv_in = intv_ff;
      drain_in = drain_ff; now_in = now_ff; dwait_in = dwait_ff;
      c_cr_in = c_cr_ff; c_rj_in = c_rj_ff; c_at_in = c_at_ff;
      c_tm_in = c_tm_ff; c_ex_in = c_ex_ff;
      ov_in = ov_ff && rsp_stall; oev_in = oev_ff; oid_in = oid_ff;
      olast_in = olast_ff; orefresh_in = 1'b0;
      s_we = 1'b0; d_we = 1'b0; s_wa = free_ff; d_wa = free_ff;
      s_wkey = cmd_ff.subscriber_id;

      if (csr_write) begin
         if (csr_index == stwa_pkg::CSR_TIMEOUT) timeout_in = csr_data;
         else intv_in = csr_data[9:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && out_free) begin
               cmd_in = req_data; ptr_in = 7'd0; hit_in = 1'b0;
               free_ok_in = 1'b0; any_in = 1'b0;
               case (req_data.mode)
                  stwa_pkg::MODE_CREATE: begin
                     if (drain_ff) begin
                        state_in = S_FIN; oev_in = stwa_pkg::EV_UNAVAILABLE;
                     end else begin
                        state_in = S_DENY;
                     end
                  end
                  stwa_pkg::MODE_DENY: begin
                     if (req_data.subscriber_id > stwa_pkg::ID_MAX) begin
                        state_in = S_FIN; oev_in = stwa_pkg::EV_BL_REFUSED;
                     end else state_in = S_DENY;
                  end
                  stwa_pkg::MODE_TERM, stwa_pkg::MODE_SWEEP: state_in = S_SLOT;
                  stwa_pkg::MODE_DRAIN: begin
                     drain_in = 1'b1; dwait_in = 32'd0;
                     state_in = S_FIN; oev_in = stwa_pkg::EV_DONE;
                  end
                  stwa_pkg::MODE_TICK: begin
                     now_in = now_ff + 32'd1;
                     oev_in = stwa_pkg::EV_TICK;
                     state_in = S_FIN;
                     if (drain_ff) begin
                        dwait_in = dwait_ff + 32'd1;
                        if (dwait_ff + 32'd1 >= iv) begin
                           dwait_in = 32'd0;
                           if (sval_ff != 64'd0) state_in = S_SLOT;
                        end
                     end
                  end
                  stwa_pkg::MODE_STATS: begin
                     state_in = S_FIN; oev_in = stwa_pkg::EV_STATS;
                  end
                  default: state_in = S_IDLE;
               endcase
               oid_in = (req_data.mode == stwa_pkg::MODE_SWEEP ||
                         req_data.mode == stwa_pkg::MODE_DRAIN ||
                         req_data.mode == stwa_pkg::MODE_TICK ||
                         req_data.mode == stwa_pkg::MODE_STATS) ?
                        50'd0 : req_data.subscriber_id;
            end
         end
         S_DENY: begin
            if (ptr_ff < 7'd64) begin
               ptr_in = ptr_ff + 7'd1; chk_in = ptr_ff[5:0]; chk_vld_in = 1'b1;
            end
            if (chk_vld_ff) begin
               if (dval_ff[chk_ff] && d_key_rd == cmd_ff.subscriber_id)
                  hit_in = 1'b1;
               if (!dval_ff[chk_ff] && !free_ok_ff) begin
                  free_ok_in = 1'b1; free_in = chk_ff;
               end
               if (chk_ff == 6'd63) begin
                  ptr_in = 7'd0;
                  if (cmd_ff.mode == stwa_pkg::MODE_DENY) begin
                     state_in = S_FIN;
                     if (hit_in || !free_ok_in) oev_in = stwa_pkg::EV_BL_REFUSED;
                     else begin
                        d_we = 1'b1; d_wa = free_in;
                        dval_in[free_in] = 1'b1;
                        oev_in = stwa_pkg::EV_BL_ADDED;
                     end
                  end else if (hit_in) begin
                     state_in = S_FIN; oev_in = stwa_pkg::EV_BLACKLISTED;
                     c_rj_in = c_rj_ff + 32'd1; c_at_in = c_at_ff + 32'd1;
                  end else begin
                     state_in = S_SLOT; free_ok_in = 1'b0;
                  end
               end
            end
         end
         S_SLOT: begin
            // sweep waits for the result register before each step
            if (scan_hold) begin
               chk_vld_in = chk_vld_ff;
            end else begin
               if (ptr_ff < 7'd64) begin
                  ptr_in = ptr_ff + 7'd1; chk_in = ptr_ff[5:0];
                  chk_vld_in = 1'b1;
               end
               if (chk_vld_ff) begin
                  unique case (cmd_ff.mode)
                     stwa_pkg::MODE_CREATE: begin
                        if (sval_ff[chk_ff] && s_key_rd == cmd_ff.subscriber_id)
                           hit_in = 1'b1;
                        if (!sval_ff[chk_ff] && !free_ok_ff) begin
                           free_ok_in = 1'b1; free_in = chk_ff;
                        end
                     end
                     stwa_pkg::MODE_TERM: begin
                        if (sval_ff[chk_ff] && s_key_rd == cmd_ff.subscriber_id
                            && !hit_ff) begin
                           hit_in = 1'b1; free_in = chk_ff;
                        end
                     end
                     stwa_pkg::MODE_SWEEP: begin
                        // each deletion is sent once the next one or the end
                        // is known, so the final one can carry last
                        if (sval_ff[chk_ff] && age >= timeout_ff) begin
                           sval_in[chk_ff] = 1'b0; pkey_in = s_key_rd;
                           any_in = 1'b1;
                           if (any_ff) begin
                              act_in = act_ff - 7'd1; c_ex_in = c_ex_ff + 32'd1;
                              ov_in = 1'b1; oev_in = stwa_pkg::EV_DELETED;
                              oid_in = pkey_ff; olast_in = 1'b0;
                              orefresh_in = 1'b1;
                           end
                        end
                     end
                     default: begin
                        if (sval_ff[chk_ff] && !hit_ff) begin
                           hit_in = 1'b1; free_in = chk_ff; oid_in = s_key_rd;
                        end
                     end
                  endcase
                  if (chk_ff == 6'd63) begin
                     state_in = S_FIN;
                     unique case (cmd_ff.mode)
                        stwa_pkg::MODE_CREATE: begin
                           if (hit_in) oev_in = stwa_pkg::EV_EXISTS;
                           else if (!free_ok_in) oev_in = stwa_pkg::EV_FULL;
                           else begin
                              s_we = 1'b1; s_wa = free_in;
                              sval_in[free_in] = 1'b1; act_in = act_ff + 7'd1;
                              c_cr_in = c_cr_ff + 32'd1;
                              c_at_in = c_at_ff + 32'd1;
                              oev_in = stwa_pkg::EV_CREATED;
                           end
                        end
                        stwa_pkg::MODE_TERM: begin
                           if (hit_in) begin
                              sval_in[free_in] = 1'b0; act_in = act_ff - 7'd1;
                              c_tm_in = c_tm_ff + 32'd1;
                              oev_in = stwa_pkg::EV_DELETED;
                           end else oev_in = stwa_pkg::EV_NOTFOUND;
                        end
                        stwa_pkg::MODE_SWEEP: state_in = S_WAIT;
                        default: begin
                           sval_in[free_in] = 1'b0; act_in = act_ff - 7'd1;
                           c_tm_in = c_tm_ff + 32'd1;
                           oev_in = stwa_pkg::EV_DELETED;
                        end
                     endcase
                  end
               end
            end
         end
         S_WAIT: begin
            // sweep end: send the held deletion with last, or done
            if (out_free) begin
               ov_in = 1'b1; olast_in = 1'b1; orefresh_in = 1'b1;
               state_in = S_IDLE;
               if (any_ff) begin
                  oev_in = stwa_pkg::EV_DELETED; oid_in = pkey_ff;
                  act_in = act_ff - 7'd1; c_ex_in = c_ex_ff + 32'd1;
               end else begin
                  oev_in = stwa_pkg::EV_DONE; oid_in = 50'd0;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               ov_in = 1'b1; olast_in = 1'b1; orefresh_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // counters snapshot taken with the result
   logic [31:0] o_cr_ff, o_rj_ff, o_at_ff, o_tm_ff, o_ex_ff, o_up_ff;
   logic [6:0]  o_act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; chk_vld_ff <= 1'b0; sval_ff <= '0; dval_ff <= '0;
         act_ff <= '0; timeout_ff <= 32'd60000; intv_ff <= 10'd100;
         drain_ff <= 1'b0; now_ff <= '0; dwait_ff <= '0;
         c_cr_ff <= '0; c_rj_ff <= '0; c_at_ff <= '0; c_tm_ff <= '0;
         c_ex_ff <= '0; ov_ff <= 1'b0; orefresh_ff <= 1'b0;
      end else begin
         state_ff <= state_in; chk_vld_ff <= chk_vld_in; sval_ff <= sval_in;
         dval_ff <= dval_in; act_ff <= act_in; timeout_ff <= timeout_in;
         intv_ff <= intv_in; drain_ff <= drain_in; now_ff <= now_in;
         dwait_ff <= dwait_in; c_cr_ff <= c_cr_in; c_rj_ff <= c_rj_in;
         c_at_ff <= c_at_in; c_tm_ff <= c_tm_in; c_ex_ff <= c_ex_in;
         ov_ff <= ov_in; orefresh_ff <= orefresh_in;
      end
      cmd_ff <= cmd_in; ptr_ff <= ptr_in; chk_ff <= chk_in; hit_ff <= hit_in;
      free_ok_ff <= free_ok_in; free_ff <= free_in; any_ff <= any_in;
      pkey_ff <= pkey_in;
      oev_ff <= oev_in; oid_ff <= oid_in; olast_ff <= olast_in;
      if (orefresh_in) begin
         o_cr_ff <= c_cr_in; o_rj_ff <= c_rj_in; o_at_ff <= c_at_in;
         o_tm_ff <= c_tm_in; o_ex_ff <= c_ex_in; o_up_ff <= now_in;
         o_act_ff <= act_in;
      end
   end

   assign rsp_valid = ov_ff;
   always_comb begin
      rsp_data.event_res = oev_ff;
      rsp_data.event_id = oid_ff;
      rsp_data.active_count = o_act_ff;
      rsp_data.created_count = o_cr_ff;
      rsp_data.rejected_count = o_rj_ff;
      rsp_data.attempt_count = o_at_ff;
      rsp_data.terminated_count = o_tm_ff;
      rsp_data.expired_count = o_ex_ff;
      rsp_data.uptime_ticks = o_up_ff;
      rsp_data.last = olast_ff;
   end

`ifndef SYNTHESIS
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !rsp_valid) |-> !req_stall)
      else $error("idle but stalled");
   a_active_max: assert property (@(posedge clock) disable iff (reset)
      act_ff <= 7'd64) else $error("active count overflow");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.mode != stwa_pkg::MODE_NONE)
      |=> req_stall)
      else $error("command not taken up");
`endif
endmodule
`default_nettype wire

[dv/tb_session_table_with_aging.sv]
`default_nettype none
module tb_session_table_with_aging;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   stwa_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   stwa_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   session_table_with_aging u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // shadow of the table
   logic [stwa_pkg::ID_BITS-1:0] key_q [stwa_pkg::SLOTS];
   logic                         used_q [stwa_pkg::SLOTS];
   logic [31:0]                  born_q [stwa_pkg::SLOTS];
   logic [stwa_pkg::ID_BITS-1:0] deny_q [stwa_pkg::SLOTS];
   logic                         deny_used_q [stwa_pkg::SLOTS];
   logic               drain_on;
   logic [31:0]        now_q, wait_q, timeout_q;
   logic [9:0]         interval_q;
   logic [31:0]        n_created, n_rejected, n_attempt, n_term, n_expired;

   stwa_pkg::req_type  pending_reqs [$];
   stwa_pkg::rsp_type  expected_rsps [$];
   int       errors = 0;
   int       n_accepted = 0;
   int       n_offered = 0;
   bit       hold_rsp = 1'b0;
   bit       quiet_req = 1'b0;
   bit       quiet_rsp = 1'b0;
   bit       burst_in = 1'b0;
   event     hold_go;

   function automatic int occupancy();
      int n = 0;
      for (int i = 0; i < stwa_pkg::SLOTS; i++) if (used_q[i]) n++;
      return n;
   endfunction

   function automatic void push_event(logic [3:0] ev, logic [stwa_pkg::ID_BITS-1:0] id);
      stwa_pkg::rsp_type r;
      r.event_res = ev;
      r.event_id = id;
      r.active_count = 7'(occupancy());
      r.created_count = n_created;
      r.rejected_count = n_rejected;
      r.attempt_count = n_attempt;
      r.terminated_count = n_term;
      r.expired_count = n_expired;
      r.uptime_ticks = now_q;
      r.last = 1'b0;
      expected_rsps.push_back(r);
   endfunction

   function automatic int find_key(logic [stwa_pkg::ID_BITS-1:0] id);
      for (int i = 0; i < stwa_pkg::SLOTS; i++)
         if (used_q[i] && key_q[i] == id) return i;
      return -1;
   endfunction

   function automatic bit denied(logic [stwa_pkg::ID_BITS-1:0] id);
      for (int i = 0; i < stwa_pkg::SLOTS; i++)
         if (deny_used_q[i] && deny_q[i] == id) return 1;
      return 0;
   endfunction

   function automatic void predict_session(stwa_pkg::req_type rq);
      int n0, s;
      bit hit;
      logic [9:0] iv;
      n0 = expected_rsps.size();
      case (rq.mode)
         stwa_pkg::MODE_CREATE: begin
            if (drain_on) push_event(stwa_pkg::EV_UNAVAILABLE, rq.subscriber_id);
            else if (denied(rq.subscriber_id)) begin
               n_rejected++; n_attempt++;
               push_event(stwa_pkg::EV_BLACKLISTED, rq.subscriber_id);
            end else if (find_key(rq.subscriber_id) >= 0)
               push_event(stwa_pkg::EV_EXISTS, rq.subscriber_id);
            else begin
               s = -1;
               for (int i = 0; i < stwa_pkg::SLOTS; i++)
                  if (!used_q[i] && s < 0) s = i;
               if (s < 0) push_event(stwa_pkg::EV_FULL, rq.subscriber_id);
               else begin
                  used_q[s] = 1; key_q[s] = rq.subscriber_id; born_q[s] = now_q;
                  n_created++; n_attempt++;
                  push_event(stwa_pkg::EV_CREATED, rq.subscriber_id);
               end
            end
         end
         stwa_pkg::MODE_TERM: begin
            s = find_key(rq.subscriber_id);
            if (s < 0) push_event(stwa_pkg::EV_NOTFOUND, rq.subscriber_id);
            else begin
               used_q[s] = 0; n_term++;
               push_event(stwa_pkg::EV_DELETED, rq.subscriber_id);
            end
         end
         stwa_pkg::MODE_DENY: begin
            if (rq.subscriber_id > stwa_pkg::ID_MAX || denied(rq.subscriber_id))
               push_event(stwa_pkg::EV_BL_REFUSED, rq.subscriber_id);
            else begin
               s = -1;
               for (int i = 0; i < stwa_pkg::SLOTS; i++)
                  if (!deny_used_q[i] && s < 0) s = i;
               if (s < 0) push_event(stwa_pkg::EV_BL_REFUSED, rq.subscriber_id);
               else begin
                  deny_used_q[s] = 1; deny_q[s] = rq.subscriber_id;
                  push_event(stwa_pkg::EV_BL_ADDED, rq.subscriber_id);
               end
            end
         end
         stwa_pkg::MODE_SWEEP: begin
            hit = 0;
            for (int i = 0; i < stwa_pkg::SLOTS; i++)
               if (used_q[i] && (now_q - born_q[i]) >= timeout_q) begin
                  used_q[i] = 0; n_expired++; hit = 1;
                  push_event(stwa_pkg::EV_DELETED, key_q[i]);
               end
            if (!hit) push_event(stwa_pkg::EV_DONE, '0);
         end
         stwa_pkg::MODE_DRAIN: begin
            drain_on = 1; wait_q = 0;
            push_event(stwa_pkg::EV_DONE, '0);
         end
         stwa_pkg::MODE_TICK: begin
            now_q++;
            hit = 0;
            if (drain_on) begin
               iv = (interval_q == 0) ? 10'd1 : interval_q;
               wait_q++;
               if (wait_q >= 32'(iv)) begin
                  wait_q = 0;
                  for (int i = 0; i < stwa_pkg::SLOTS; i++)
                     if (used_q[i] && !hit) begin
                        used_q[i] = 0; n_term++; hit = 1;
                        push_event(stwa_pkg::EV_DELETED, key_q[i]);
                     end
               end
            end
            if (!hit) push_event(stwa_pkg::EV_TICK, '0);
         end
         stwa_pkg::MODE_STATS: push_event(stwa_pkg::EV_STATS, '0);
         default: ;
      endcase
      if (expected_rsps.size() > n0) expected_rsps[$].last = 1'b1;
   endfunction

   // driver: a new item goes out only once the one on the bus was taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || n_accepted != n_offered) begin
            if (pending_reqs.size() > 0 && !quiet_req &&
                (burst_in || $urandom_range(99) >= 16)) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs[0];
               n_offered = n_accepted;
            end else req_valid <= 1'b0;
         end
         rsp_stall <= hold_rsp || (!quiet_rsp && $urandom_range(99) < 16);
      end
   end

   // predict on accepted transfer; pop the driver queue here
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_session(req_data);
         void'(pending_reqs.pop_front());
         n_accepted++;
      end
   end

   // long receiver hold-off
   always begin
      @(hold_go);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // check each result transfer
   always @(posedge clock) begin
      stwa_pkg::rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_data;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t unexpected result %p", $time, got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t mismatch expected %p actual %p", $time, want, got);
            end
         end
      end
   end

   function automatic logic [stwa_pkg::ID_BITS-1:0] rand_id();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[stwa_pkg::ID_BITS-1:0];
   endfunction

   task automatic add(logic [2:0] m, logic [stwa_pkg::ID_BITS-1:0] id);
      stwa_pkg::req_type r;
      r.mode = m; r.subscriber_id = id;
      pending_reqs.push_back(r);
   endtask

   task automatic drain_all();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] v);
      @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == stwa_pkg::CSR_TIMEOUT) timeout_q = v; else interval_q = v[9:0];
   endtask

   function automatic logic [stwa_pkg::ID_BITS-1:0] pick_id(
         logic [stwa_pkg::ID_BITS-1:0] pool []);
      if ($urandom_range(9) < 8) return pool[$urandom_range(pool.size() - 1)];
      return rand_id();
   endfunction

   task automatic random_phase(int count, logic [stwa_pkg::ID_BITS-1:0] pool []);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 35) add(stwa_pkg::MODE_CREATE, pick_id(pool));
         else if (r < 50) add(stwa_pkg::MODE_TERM, pick_id(pool));
         else if (r < 58) add(stwa_pkg::MODE_DENY, pick_id(pool));
         else if (r < 66) add(stwa_pkg::MODE_SWEEP, '0);
         else if (r < 68) add(stwa_pkg::MODE_DRAIN, '0);
         else if (r < 92) add(stwa_pkg::MODE_TICK, '0);
         else if (r < 97) add(stwa_pkg::MODE_STATS, '0);
         else add(stwa_pkg::MODE_NONE, rand_id());
      end
   endtask

   initial begin
      logic [stwa_pkg::ID_BITS-1:0] pool [];
      for (int i = 0; i < stwa_pkg::SLOTS; i++) begin
         used_q[i] = 0; deny_used_q[i] = 0;
      end
      drain_on = 0; now_q = 0; wait_q = 0;
      timeout_q = 60000; interval_q = 100;
      n_created = 0; n_rejected = 0; n_attempt = 0; n_term = 0; n_expired = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      write_reg(stwa_pkg::CSR_TIMEOUT, 32'd0);
      add(stwa_pkg::MODE_STATS, '0);
      add(stwa_pkg::MODE_CREATE, '0);
      add(stwa_pkg::MODE_CREATE, {stwa_pkg::ID_BITS{1'b1}});
      add(stwa_pkg::MODE_CREATE, '0);
      add(stwa_pkg::MODE_DENY, stwa_pkg::ID_MAX);
      add(stwa_pkg::MODE_DENY, stwa_pkg::ID_MAX + 1);
      add(stwa_pkg::MODE_DENY, stwa_pkg::ID_MAX);
      add(stwa_pkg::MODE_CREATE, stwa_pkg::ID_MAX);
      add(stwa_pkg::MODE_TERM, {stwa_pkg::ID_BITS{1'b1}});
      add(stwa_pkg::MODE_TERM, 50'd12345);
      add(stwa_pkg::MODE_TICK, '0);
      add(stwa_pkg::MODE_SWEEP, '0);
      add(stwa_pkg::MODE_SWEEP, '0);
      add(stwa_pkg::MODE_NONE, 50'h2AAAA_AAAA_AAAA);
      drain_all();

      // fill the table, overflow it, and one long receiver hold-off
      write_reg(stwa_pkg::CSR_TIMEOUT, 32'hFFFF_FFFF);
      burst_in = 1'b1;
      for (int i = 0; i < stwa_pkg::SLOTS + 2; i++)
         add(stwa_pkg::MODE_CREATE, 50'(1000 + i));
      -> hold_go;
      drain_all();
      burst_in = 1'b0;
      write_reg(stwa_pkg::CSR_TIMEOUT, 32'd1);
      add(stwa_pkg::MODE_TICK, '0);
      add(stwa_pkg::MODE_SWEEP, '0);
      drain_all();

      // random phases under different settings; drain is sticky, so keep it rare
      pool = new[24];
      for (int i = 0; i < 24; i++) pool[i] = rand_id();
      pool[0] = '0; pool[1] = stwa_pkg::ID_MAX;
      write_reg(stwa_pkg::CSR_INTERVAL, 32'd3);
      write_reg(stwa_pkg::CSR_TIMEOUT, 32'd4);
      quiet_req = 1'b0; quiet_rsp = 1'b1; burst_in = 1'b1;
      random_phase(60, pool);
      drain_all();
      quiet_rsp = 1'b0; burst_in = 1'b0;
      write_reg(stwa_pkg::CSR_TIMEOUT, 32'd2);
      write_reg(stwa_pkg::CSR_INTERVAL, 32'd0);
      random_phase(60, pool);
      drain_all();
      write_reg(stwa_pkg::CSR_TIMEOUT, 32'd10);
      write_reg(stwa_pkg::CSR_INTERVAL, 32'd2);
      random_phase(50, pool);
      drain_all();

      // drain with interval 1, then an interval of 1000 is written
      write_reg(stwa_pkg::CSR_INTERVAL, 32'd1);
      add(stwa_pkg::MODE_CREATE, 50'd7); add(stwa_pkg::MODE_CREATE, 50'd8);
      add(stwa_pkg::MODE_DRAIN, '0);
      add(stwa_pkg::MODE_CREATE, 50'd9);
      add(stwa_pkg::MODE_TICK, '0); add(stwa_pkg::MODE_TICK, '0);
      add(stwa_pkg::MODE_TICK, '0);
      drain_all();
      write_reg(stwa_pkg::CSR_INTERVAL, 32'd1000);

      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
